>>> design/rfo_pkg.sv
// Shared types and constants for the rectangle fill/outline rasterizer.
// No dependencies; imported by every module of the block.
package rfo_pkg;

    // Geometry compare width: Q15.8 sum plus one unit, signed.
    localparam int GEO_W      = 26;
    // Enough bits for any effective canvas dimension (up to 1024).
    localparam int DIM_EXT_W  = 11;
    // Widest canvas address (1024 x 1024 pixels).
    localparam int ADDR_MAX_W = 20;
    localparam int CFG_DIM_W  = 9;
    localparam int CHAR_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_DIM_W-1:0] RST_CANVAS_WIDTH  = 9'd256;
    localparam logic [CFG_DIM_W-1:0] RST_CANVAS_HEIGHT = 9'd256;
    localparam logic [CHAR_W-1:0]    RST_BACKGROUND    = 8'd32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_IDX_BG     = 2'd2;

    // Command codes on the func field.
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // One pixel step in Q15.8.
    localparam logic signed [GEO_W-1:0] ONE_UNIT = 26'sd256;

    // Classified operation handed from front to back.
    typedef enum logic [2:0] {
        OP_CLEAR,   // sweep, paint everything with ch
        OP_DRAW,    // sweep, paint by rectangle test
        OP_READ,    // one memory read
        OP_BAD,     // rejected draw: reply bad_rect
        OP_ZERO     // reply zeros, no canvas access
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [CHAR_W-1:0]       ch;
        logic                    filled;
        logic signed [GEO_W-1:0] x_lo;     // left edge
        logic signed [GEO_W-1:0] x_edge;   // left edge + 1
        logic signed [GEO_W-1:0] x_hi;     // right edge
        logic signed [GEO_W-1:0] x_hedge;  // right edge - 1
        logic signed [GEO_W-1:0] y_lo;
        logic signed [GEO_W-1:0] y_edge;
        logic signed [GEO_W-1:0] y_hi;
        logic signed [GEO_W-1:0] y_hedge;
        logic [ADDR_MAX_W-1:0]   addr;     // read address
    } t_cmd;

endpackage

>>> design/rfo_front.sv
// Front end: accepts items and classifies them into queue commands.
// Depends on rfo_pkg; feeds rfo_queue.
module rfo_front
    import rfo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                     i_valid,
    input  logic                     i_full,
    output logic                     o_stall,
    output logic                     o_push,
    output t_cmd                     o_cmd,
    input  logic [WW-1:0]            i_w_eff,
    input  logic [HW-1:0]            i_h_eff,
    input  logic [CHAR_W-1:0]        i_bg,
    input  logic [1:0]               i_func,
    input  logic signed [23:0]       i_rect_x,
    input  logic signed [23:0]       i_rect_y,
    input  logic signed [23:0]       i_rect_w,
    input  logic signed [23:0]       i_rect_h,
    input  logic                     i_filled,
    input  logic [CHAR_W-1:0]        i_draw_char,
    input  logic [7:0]               i_read_col,
    input  logic [7:0]               i_read_row
);

    logic signed [GEO_W-1:0] x0, y0, xr, yb;
    logic                    size_bad;
    logic                    rd_in_range;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign x0 = GEO_W'(i_rect_x);
    assign y0 = GEO_W'(i_rect_y);
    assign xr = x0 + GEO_W'(i_rect_w);
    assign yb = y0 + GEO_W'(i_rect_h);

    assign size_bad    = (i_rect_w <= 24'sd0) || (i_rect_h <= 24'sd0);
    assign rd_in_range = (DIM_EXT_W'(i_read_col) < DIM_EXT_W'(i_w_eff)) &&
                         (DIM_EXT_W'(i_read_row) < DIM_EXT_W'(i_h_eff));

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_ZERO;
        o_cmd.ch      = i_draw_char;
        o_cmd.filled  = i_filled;
        o_cmd.x_lo    = x0;
        o_cmd.x_edge  = x0 + ONE_UNIT;
        o_cmd.x_hi    = xr;
        o_cmd.x_hedge = xr - ONE_UNIT;
        o_cmd.y_lo    = y0;
        o_cmd.y_edge  = y0 + ONE_UNIT;
        o_cmd.y_hi    = yb;
        o_cmd.y_hedge = yb - ONE_UNIT;
        // row-major: row * width + col
        o_cmd.addr    = ADDR_MAX_W'(i_read_row) * ADDR_MAX_W'(i_w_eff)
                      + ADDR_MAX_W'(i_read_col);
        case (i_func)
            FUNC_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                o_cmd.ch = i_bg;
            end
            FUNC_DRAW: begin
                o_cmd.op = size_bad ? OP_BAD : OP_DRAW;
            end
            FUNC_READ: begin
                o_cmd.op = rd_in_range ? OP_READ : OP_ZERO;
            end
            default: begin
                o_cmd.op = OP_ZERO;
            end
        endcase
    end

endmodule

>>> design/rfo_queue.sv
// Short command queue between front and back.
// Depends on rfo_pkg (t_cmd, QUEUE_DEPTH).
module rfo_queue
    import rfo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_cmd o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> design/rfo_back.sv
// Back end: canvas memory, pixel sweep for clear/draw, reads, result register.
// Depends on rfo_pkg; pops commands from rfo_queue.
module rfo_back
    import rfo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [COLW-1:0]   i_w_m1,
    input  logic [ROWW-1:0]   i_h_m1,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_pixel_char,
    output logic              o_bad_rect
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [COLW-1:0]   r_col, n_col;
    logic [ROWW-1:0]   r_row, n_row;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_pixel, n_pixel;
    logic              r_bad, n_bad;

    logic [CHAR_W-1:0] r_canvas [DEPTH];
    logic [CHAR_W-1:0] r_rdata;
    logic              mem_we;

    logic signed [GEO_W-1:0] px, py;
    logic                    in_rect, near_edge, paint;

    assign px = $signed({{(GEO_W - COLW - 8){1'b0}}, r_col, 8'h00});
    assign py = $signed({{(GEO_W - ROWW - 8){1'b0}}, r_row, 8'h00});

    assign in_rect   = (px >= r_cmd.x_lo) && (px <= r_cmd.x_hi) &&
                       (py >= r_cmd.y_lo) && (py <= r_cmd.y_hi);
    assign near_edge = (px < r_cmd.x_edge) || (px > r_cmd.x_hedge) ||
                       (py < r_cmd.y_edge) || (py > r_cmd.y_hedge);
    assign paint     = (r_cmd.op == OP_CLEAR) ||
                       (in_rect && (near_edge || r_cmd.filled));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_col       = r_col;
        n_row       = r_row;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_pixel     = r_pixel;
        n_bad       = r_bad;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_col  = '0;
                    n_row  = '0;
                    n_addr = '0;
                    case (i_cmd.op)
                        OP_CLEAR, OP_DRAW: begin
                            n_state = S_SWEEP;
                        end
                        OP_READ: begin
                            // read of i_cmd.addr lands in r_rdata this edge
                            n_state = S_READ;
                        end
                        OP_BAD: begin
                            n_out_valid = 1'b1;
                            n_pixel     = '0;
                            n_bad       = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_pixel     = '0;
                            n_bad       = 1'b0;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                mem_we = paint;
                n_addr = r_addr + AW'(1);
                if (r_col == i_w_m1) begin
                    n_col = '0;
                    if (r_row == i_h_m1) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_pixel     = '0;
                        n_bad       = 1'b0;
                    end else begin
                        n_row = r_row + ROWW'(1);
                    end
                end else begin
                    n_col = r_col + COLW'(1);
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_pixel     = r_rdata;
                n_bad       = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_col   <= n_col;
        r_row   <= n_row;
        r_addr  <= n_addr;
        r_pixel <= n_pixel;
        r_bad   <= n_bad;
    end

    // Canvas: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_canvas[r_addr] <= r_cmd.ch;
        end
        r_rdata <= r_canvas[i_cmd.addr[AW-1:0]];
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_char = r_pixel;
    assign o_bad_rect   = r_bad;

endmodule

>>> design/rect_fill_outline_raster.sv
// Rectangle fill/outline rasterizer on a byte-per-pixel character canvas.
// Each item yields exactly one result item. A clear or a draw sweeps the
// canvas in use one pixel per cycle; the single write port of the canvas
// memory sets that rate. A read pops the queue together with the registered
// memory read, then loads the result register and hands the result off; a
// rejected draw, a read outside the canvas or an unused command loads the
// result register on the pop itself. Items are queued (two deep) ahead
// of the sweep, so the input side keeps accepting while a sweep runs until
// the queue fills. Geometry is Q15.8: pixel (c,r) sits at (c*256, r*256),
// and a pixel inside the rectangle (edges included) is painted if the
// rectangle is filled or the pixel is less than one unit from an edge.
// The canvas is not cleared by reset: issue a clear before reading pixels.
// Configuration (width, height, background) may be written only while the
// block is idle; width and height are clamped to 1..MAX_WIDTH/MAX_HEIGHT.
module rect_fill_outline_raster
    import rfo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [CFG_DIM_W-1:0] i_cfg_data,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic signed [23:0]   i_rect_x,
    input  logic signed [23:0]   i_rect_y,
    input  logic signed [23:0]   i_rect_w,
    input  logic signed [23:0]   i_rect_h,
    input  logic                 i_filled,
    input  logic [CHAR_W-1:0]    i_draw_char,
    input  logic [7:0]           i_read_col,
    input  logic [7:0]           i_read_row,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CHAR_W-1:0]    o_pixel_char,
    output logic                 o_bad_rect
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // config registers
    logic [CFG_DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [CHAR_W-1:0]    r_bg;

    // clamped canvas size
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [COLW-1:0] w_m1;
    logic [ROWW-1:0] h_m1;

    // front -> queue -> back
    t_cmd front_cmd, head_cmd;
    logic front_push, q_full, q_nonempty, back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_CANVAS_WIDTH;
            r_cfg_h <= RST_CANVAS_HEIGHT;
            r_bg    <= RST_BACKGROUND;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_IDX_BG:     r_bg    <= i_cfg_data[CHAR_W-1:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // zero acts as 1, anything above the maximum acts as the maximum
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (DIM_EXT_W'(r_cfg_w) > DIM_EXT_W'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (DIM_EXT_W'(r_cfg_h) > DIM_EXT_W'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    assign w_m1 = COLW'(w_eff - WW'(1));
    assign h_m1 = ROWW'(h_eff - HW'(1));

    rfo_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_valid     (i_in_valid),
        .i_full      (q_full),
        .o_stall     (o_in_stall),
        .o_push      (front_push),
        .o_cmd       (front_cmd),
        .i_w_eff     (w_eff),
        .i_h_eff     (h_eff),
        .i_bg        (r_bg),
        .i_func      (i_func),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_filled    (i_filled),
        .i_draw_char (i_draw_char),
        .i_read_col  (i_read_col),
        .i_read_row  (i_read_row)
    );

    rfo_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_push),
        .i_cmd      (front_cmd),
        .o_full     (q_full),
        .i_pop      (back_pop),
        .o_nonempty (q_nonempty),
        .o_head     (head_cmd)
    );

    rfo_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_w_m1       (w_m1),
        .i_h_m1       (h_m1),
        .i_cmd_valid  (q_nonempty),
        .i_cmd        (head_cmd),
        .o_pop        (back_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_char (o_pixel_char),
        .o_bad_rect   (o_bad_rect)
    );

endmodule

>>> design/rfo_checker.sv
// Port-level checks for rect_fill_outline_raster, bound to the top level.
// Depends on rfo_pkg for field widths.
module rfo_checker
    import rfo_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [CHAR_W-1:0]    o_pixel_char,
    input logic                 o_bad_rect
);

    // a result held back by stall stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a rejected draw never carries a pixel
    a_bad_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_rect |-> o_pixel_char == '0)
        else $error("bad_rect with nonzero pixel_char");

    // reset empties the result register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // reset empties the queue, so input is open
    a_rst_queue: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind rect_fill_outline_raster rfo_checker u_rfo_checker (.*);
